>>> src/ascc_pkg.sv
package ascc_pkg;

	localparam int SAMPLE_LIMIT = 1024;
	localparam int CNT_W = 11;
	localparam int SUM_W = 26;
	localparam int SQ_W = 42;
	localparam int TOL_W = 16;
	localparam int CFG_W = 16;
	localparam int ACC_W = 128;
	localparam int DIV_STEPS = SUM_W;
	localparam int DIVCNT_W = $clog2(DIV_STEPS + 1);
	localparam int OP_LAST = 12;

	typedef enum logic [1:0] {
		REG_MAX_SAMPLES = 2'd0,
		REG_SAMPLES_PER_BATCH = 2'd1,
		REG_MAX_TOLERANCE = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		SEL_S, SEL_N, SEL_QLO, SEL_QHI, SEL_ALO, SEL_AHI, SEL_BLO, SEL_BHI,
		SEL_CLO, SEL_CHI, SEL_T, SEL_NM1, SEL_K2401, SEL_K625
	} opnd_sel_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_A, DST_VAR, DST_B, DST_C, DST_CMP
	} dest_t;

	typedef struct packed {
		opnd_sel_t a;
		opnd_sel_t b;
		logic [1:0] sh;
		logic first;
		dest_t dest;
	} mac_op_t;

	typedef struct packed {
		logic mul;
		logic acc;
		logic first;
		logic [1:0] sh;
	} mac_ctrl_t;

	// Test: 2401*(n*Q - S*S)*2^32 <= 625*T*T*(n-1)*S*S, in 32-bit limbs
	function automatic mac_op_t op_decode(input logic [3:0] idx);
		mac_op_t o;
		o = '{SEL_S, SEL_S, 2'd0, 1'b1, DST_A};
		case (idx)
			4'd0: o = '{SEL_S, SEL_S, 2'd0, 1'b1, DST_A};
			4'd1: o = '{SEL_N, SEL_QLO, 2'd0, 1'b1, DST_NONE};
			4'd2: o = '{SEL_N, SEL_QHI, 2'd1, 1'b0, DST_VAR};
			4'd3: o = '{SEL_BLO, SEL_K2401, 2'd0, 1'b1, DST_NONE};
			4'd4: o = '{SEL_BHI, SEL_K2401, 2'd1, 1'b0, DST_B};
			4'd5: o = '{SEL_T, SEL_T, 2'd0, 1'b1, DST_C};
			4'd6: o = '{SEL_CLO, SEL_K625, 2'd0, 1'b1, DST_C};
			4'd7: o = '{SEL_CLO, SEL_NM1, 2'd0, 1'b1, DST_NONE};
			4'd8: o = '{SEL_CHI, SEL_NM1, 2'd1, 1'b0, DST_C};
			4'd9: o = '{SEL_ALO, SEL_CLO, 2'd0, 1'b1, DST_NONE};
			4'd10: o = '{SEL_ALO, SEL_CHI, 2'd1, 1'b0, DST_NONE};
			4'd11: o = '{SEL_AHI, SEL_CLO, 2'd1, 1'b0, DST_NONE};
			4'd12: o = '{SEL_AHI, SEL_CHI, 2'd2, 1'b0, DST_CMP};
			default: o = '{SEL_S, SEL_S, 2'd0, 1'b1, DST_NONE};
		endcase
		return o;
	endfunction

endpackage

>>> src/ascc_mac.sv
module ascc_mac (
	input logic clk,
	input logic arst_n,
	input ascc_pkg::mac_ctrl_t ctrl,
	input logic [31:0] a,
	input logic [31:0] b,
	output logic [ascc_pkg::ACC_W-1:0] acc
);
	import ascc_pkg::*;

	logic [63:0] prod_s1;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] addend;

	always_comb begin
		case (ctrl.sh)
			2'd0: addend = {64'd0, prod_s1};
			2'd1: addend = {32'd0, prod_s1, 32'd0};
			2'd2: addend = {prod_s1, 64'd0};
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_s1 <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc) begin
			acc_q <= (ctrl.first ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

>>> src/ascc_div.sv
module ascc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [ascc_pkg::SUM_W-1:0] dividend,
	input logic [ascc_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic [ascc_pkg::SUM_W-1:0] quotient,
	output logic [ascc_pkg::CNT_W-1:0] remainder
);
	import ascc_pkg::*;

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [CNT_W:0] trial;
	logic ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIVCNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

>>> src/adaptive_sample_convergence_core.sv
// One sample per input beat; s_tready is high only while idle.
// Non-test sample: accumulate, then a 26-step remainder for the batch check.
// Test sample: adds 13 products on the shared 32x32 multiply-accumulate.
// Finishing sample: adds the three mean divides, then held until taken.
// Reset (arst_n low): sums and count cleared, registers to 64 / 32 / 3277.
module adaptive_sample_convergence_core (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// red[15:0], green[31:16], blue[47:32], illuminance[63:48], x[75:64], y[87:76]
	input logic [87:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// mean_red[15:0], mean_green[31:16], mean_blue[47:32], samples_used[58:48],
	// out_x[70:59], out_y[82:71], zero pad
	output logic [87:0] m_tdata,
	// converged[0]
	output logic m_tuser,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [ascc_pkg::CFG_W-1:0] cfg_data
);
	import ascc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_SUM = 8'b00000010,
		S_MOD = 8'b00000100,
		S_MUL = 8'b00001000,
		S_ACC = 8'b00010000,
		S_ST = 8'b00100000,
		S_DIV = 8'b01000000,
		S_OUT = 8'b10000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] max_q, batch_q;
	logic [TOL_W-1:0] tol_q;
	logic [SUM_W-1:0] red_q, green_q, blue_q, illum_q;
	logic [SQ_W-1:0] sq_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0] in_r_q, in_g_q, in_b_q, in_l_q;
	logic [11:0] in_x_q, in_y_q;
	logic [63:0] ra_q, rb_q, rc_q;
	logic [3:0] op_q;
	logic [1:0] chan_q;
	logic conv_q;
	logic [15:0] o_r_q, o_g_q, o_b_q;
	logic [CNT_W-1:0] o_n_q;
	logic o_conv_q;
	logic [11:0] o_x_q, o_y_q;

	mac_op_t op;
	mac_ctrl_t mctl;
	logic [31:0] opa, opb;
	logic [ACC_W-1:0] acc;
	logic div_start, div_done;
	logic [SUM_W-1:0] div_dnd, div_quo;
	logic [CNT_W-1:0] div_dsr, div_rem;
	logic [CNT_W-1:0] limit, batch, n_m1;
	logic finish_now, conv_now, test_en;

	assign op = op_decode(op_q);
	assign n_m1 = count_q - 1'b1;
	assign batch = (batch_q == '0) ? CNT_W'(1) : batch_q;
	always_comb begin
		if (max_q == '0) limit = CNT_W'(1);
		else if (max_q > CNT_W'(SAMPLE_LIMIT)) limit = CNT_W'(SAMPLE_LIMIT);
		else limit = max_q;
	end

	function automatic logic [31:0] opnd(input opnd_sel_t s, input logic [SUM_W-1:0] sum,
			input logic [CNT_W-1:0] n, input logic [SQ_W-1:0] q, input logic [63:0] ra,
			input logic [63:0] rb, input logic [63:0] rc, input logic [TOL_W-1:0] t,
			input logic [CNT_W-1:0] nm1);
		logic [31:0] v;
		v = '0;
		case (s)
			SEL_S: v = 32'(sum);
			SEL_N: v = 32'(n);
			SEL_QLO: v = q[31:0];
			SEL_QHI: v = 32'(q[SQ_W-1:32]);
			SEL_ALO: v = ra[31:0];
			SEL_AHI: v = ra[63:32];
			SEL_BLO: v = rb[31:0];
			SEL_BHI: v = rb[63:32];
			SEL_CLO: v = rc[31:0];
			SEL_CHI: v = rc[63:32];
			SEL_T: v = 32'(t);
			SEL_NM1: v = 32'(nm1);
			SEL_K2401: v = 32'd2401;
			SEL_K625: v = 32'd625;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opa = opnd(op.a, illum_q, count_q, sq_q, ra_q, rb_q, rc_q, tol_q, n_m1);
	assign opb = opnd(op.b, illum_q, count_q, sq_q, ra_q, rb_q, rc_q, tol_q, n_m1);

	assign mctl.mul = (state_q == S_MUL);
	assign mctl.acc = (state_q == S_ACC);
	assign mctl.first = op.first;
	assign mctl.sh = op.sh;

	ascc_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctrl(mctl), .a(opa), .b(opb), .acc(acc)
	);

	ascc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dnd),
		.divisor(div_dsr), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	assign test_en = (count_q >= CNT_W'(2)) && (div_rem == '0);
	assign conv_now = ({32'd0, rb_q, 32'd0} <= acc);
	always_comb begin
		finish_now = 1'b0;
		if (state_q == S_MOD && div_done && !test_en) finish_now = count_q >= limit;
		if (state_q == S_ST && op.dest == DST_CMP) finish_now = conv_now || count_q >= limit;
	end

	// Divider feed: batch remainder, then the three channel means
	always_comb begin
		div_start = 1'b0;
		div_dnd = SUM_W'(count_q + 1'b1);
		div_dsr = batch;
		if (state_q == S_SUM) begin
			div_start = 1'b1;
		end else if (finish_now) begin
			div_start = 1'b1;
			div_dnd = red_q;
			div_dsr = count_q;
		end else if (state_q == S_DIV && div_done && chan_q != 2'd2) begin
			div_start = 1'b1;
			div_dnd = (chan_q == 2'd0) ? green_q : blue_q;
			div_dsr = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= CNT_W'(64);
			batch_q <= CNT_W'(32);
			tol_q <= TOL_W'(3277);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MAX_SAMPLES: max_q <= cfg_data[CNT_W-1:0];
				REG_SAMPLES_PER_BATCH: batch_q <= cfg_data[CNT_W-1:0];
				REG_MAX_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_r_q <= s_tdata[15:0];
			in_g_q <= s_tdata[31:16];
			in_b_q <= s_tdata[47:32];
			in_l_q <= s_tdata[63:48];
			in_x_q <= s_tdata[75:64];
			in_y_q <= s_tdata[87:76];
		end
		if (state_q == S_ST) begin
			case (op.dest)
				DST_A: ra_q <= acc[63:0];
				DST_VAR: rb_q <= (acc[63:0] >= ra_q) ? acc[63:0] - ra_q : 64'd0;
				DST_B: rb_q <= acc[63:0];
				DST_C: rc_q <= acc[63:0];
				default: ;
			endcase
		end
		if (state_q == S_DIV && div_done) begin
			case (chan_q)
				2'd0: o_r_q <= div_quo[15:0];
				2'd1: o_g_q <= div_quo[15:0];
				default: begin
					o_b_q <= div_quo[15:0];
					o_n_q <= count_q;
					o_conv_q <= conv_q;
					o_x_q <= in_x_q;
					o_y_q <= in_y_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
			illum_q <= '0;
			sq_q <= '0;
			count_q <= '0;
			op_q <= '0;
			chan_q <= '0;
			conv_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_SUM;
				end
				S_SUM: begin
					red_q <= red_q + SUM_W'(in_r_q);
					green_q <= green_q + SUM_W'(in_g_q);
					blue_q <= blue_q + SUM_W'(in_b_q);
					illum_q <= illum_q + SUM_W'(in_l_q);
					sq_q <= sq_q + SQ_W'({16'd0, in_l_q} * {16'd0, in_l_q});
					count_q <= count_q + 1'b1;
					conv_q <= 1'b0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (div_done) begin
						if (test_en) begin
							op_q <= '0;
							state_q <= S_MUL;
						end else if (finish_now) begin
							chan_q <= '0;
							state_q <= S_DIV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (op.dest == DST_NONE) begin
						op_q <= op_q + 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_ST;
					end
				end
				S_ST: begin
					if (op.dest == DST_CMP) begin
						conv_q <= conv_now;
						chan_q <= '0;
						state_q <= finish_now ? S_DIV : S_IDLE;
					end else begin
						op_q <= op_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (chan_q == 2'd2) begin
							red_q <= '0;
							green_q <= '0;
							blue_q <= '0;
							illum_q <= '0;
							sq_q <= '0;
							count_q <= '0;
							state_q <= S_OUT;
						end else begin
							chan_q <= chan_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {5'd0, o_y_q, o_x_q, o_n_q, o_b_q, o_g_q, o_r_q};
	assign m_tuser = o_conv_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output open together");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SAMPLE_LIMIT)) else $error("sample count past limit");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready && count_q == '0)
		else $error("state not cleared after result");
	a_conv_n: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> o_n_q >= CNT_W'(2))
		else $error("converged with fewer than two samples");
	a_test_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> op_q <= 4'(OP_LAST)) else $error("op index out of range");

endmodule

>>> tb/tb_adaptive_sample_convergence_core.sv
`timescale 1ns / 100ps

module tb_adaptive_sample_convergence_core;
	import ascc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] illum;
		logic [11:0] x;
		logic [11:0] y;
	} sample_t;

	typedef struct packed {
		logic [15:0] mean_red;
		logic [15:0] mean_green;
		logic [15:0] mean_blue;
		logic [10:0] used;
		logic        conv;
		logic [11:0] x;
		logic [11:0] y;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	adaptive_sample_convergence_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor copy of registers and accumulators
	logic [10:0] pr_max = 11'd64;
	logic [10:0] pr_batch = 11'd32;
	logic [15:0] pr_tol = 16'd3277;
	logic [25:0] acc_red, acc_green, acc_blue, acc_illum;
	logic [41:0] acc_sq;
	logic [10:0] acc_cnt;

	pixel_t pending_pixels[$];
	int snd_idle = 0;
	int rcv_idle = 0;
	logic rcv_hold = 1'b0;
	int mismatches = 0;
	int pixels_seen = 0;
	int samples_sent = 0;
	int converged_seen = 0;
	int wd_count = 0;

	function automatic logic interval_passes(logic [10:0] n);
		logic [63:0] s2, nq, var_n, left, rfac;
		logic [127:0] l128, r128;
		s2 = 64'(acc_illum) * 64'(acc_illum);
		nq = 64'(n) * 64'(acc_sq);
		var_n = (nq >= s2) ? nq - s2 : 64'd0;
		left = var_n * 64'd2401;
		rfac = 64'd625 * 64'(pr_tol) * 64'(pr_tol) * 64'(n - 11'd1);
		l128 = {left, 32'd0};
		r128 = 128'(s2) * 128'(rfac);
		return l128 <= r128;
	endfunction

	task automatic accumulate_sample(input sample_t s);
		logic [10:0] lim, bat, n;
		logic conv;
		pixel_t p;
		lim = (pr_max == 0) ? 11'd1 : (pr_max > SAMPLE_LIMIT) ? 11'(SAMPLE_LIMIT) : pr_max;
		bat = (pr_batch == 0) ? 11'd1 : pr_batch;
		acc_red += 26'(s.red);
		acc_green += 26'(s.green);
		acc_blue += 26'(s.blue);
		acc_illum += 26'(s.illum);
		acc_sq += 42'(32'(s.illum) * 32'(s.illum));
		acc_cnt += 11'd1;
		n = acc_cnt;
		conv = (n >= 2 && (n % bat) == 0) ? interval_passes(n) : 1'b0;
		if (conv || n >= lim) begin
			p.mean_red = 16'(acc_red / n);
			p.mean_green = 16'(acc_green / n);
			p.mean_blue = 16'(acc_blue / n);
			p.used = n;
			p.conv = conv;
			p.x = s.x;
			p.y = s.y;
			pending_pixels.push_back(p);
			acc_red = '0; acc_green = '0; acc_blue = '0;
			acc_illum = '0; acc_sq = '0; acc_cnt = '0;
		end
	endtask

	// called right after a rising edge; leaves valid high for a back-to-back beat
	task automatic send_sample(input sample_t s);
		int gap;
		gap = ($urandom_range(0, 99) < snd_idle) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s.y, s.x, s.illum, s.blue, s.green, s.red};
		do @(posedge clk); while (!s_tready);
		accumulate_sample(s);
		samples_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		s_tvalid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAX_SAMPLES: pr_max = val[10:0];
			REG_SAMPLES_PER_BATCH: pr_batch = val[10:0];
			default: pr_tol = val;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] mx, input logic [15:0] bt, input logic [15:0] tl);
		drain();
		write_reg(REG_MAX_SAMPLES, mx);
		write_reg(REG_SAMPLES_PER_BATCH, bt);
		write_reg(REG_MAX_TOLERANCE, tl);
	endtask

	function automatic sample_t make_sample(input int base, input int spread,
			input logic [11:0] x, input logic [11:0] y);
		sample_t s;
		int il;
		il = base + int'($urandom_range(0, spread));
		s.red = 16'($urandom);
		s.green = 16'($urandom);
		s.blue = 16'($urandom);
		s.illum = (il > 65535) ? 16'hFFFF : 16'(il);
		s.x = x;
		s.y = y;
		return s;
	endfunction

	task automatic test_directed();
		// single-sample pixels at the field extremes
		set_config(16'd1, 16'd32, 16'd3277);
		send_sample('0);
		send_sample('1);
		send_sample({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 12'hFFF, 12'h000});
		// limit of zero behaves as one
		set_config(16'd0, 16'd1, 16'd100);
		send_sample({16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 12'h00F, 12'hF00});
		send_sample('1);
		// batch of zero acts as one; zero illuminance converges at two
		set_config(16'd8, 16'd0, 16'd0);
		for (int i = 0; i < 2; i++) send_sample({16'hFFFF, 16'd7, 16'd9, 16'd0, 12'd5, 12'd6});
		// test skipped at n = 1, then passes at two with equal samples
		set_config(16'd3, 16'd1, 16'hFFFF);
		for (int i = 0; i < 2; i++) send_sample({16'd100, 16'd200, 16'd300, 16'd500, 12'd1, 12'd2});
		// test and limit on the same sample
		set_config(16'd4, 16'd4, 16'hFFFF);
		for (int i = 0; i < 4; i++) send_sample({16'd1, 16'd2, 16'd3, 16'd4000, 12'd9, 12'd9});
		// limit lowered while a pixel is open
		set_config(16'd64, 16'd64, 16'd0);
		for (int i = 0; i < 5; i++) send_sample(make_sample(1000, 9000, 12'd3, 12'd4));
		drain();
		write_reg(REG_MAX_SAMPLES, 16'd3);
		send_sample(make_sample(1000, 9000, 12'd3, 12'd4));
		// register values wider than the fields
		set_config(16'hF802, 16'hF802, 16'd65535);
		for (int i = 0; i < 2; i++) send_sample(make_sample(0, 65535, 12'd7, 12'd8));
	endtask

	task automatic test_full_pixel();
		sample_t s;
		// largest pixel, never converges: every sample at full scale but illuminance
		set_config(16'd1024, 16'd1024, 16'd0);
		for (int i = 0; i < 1024; i++) begin
			s = make_sample(0, 65535, 12'hFFF, 12'hFFF);
			s.red = 16'hFFFF; s.green = 16'hFFFF; s.blue = 16'hFFFF;
			if (i == 0) s.illum = 16'hFFFF;
			if (i == 1) s.illum = 16'h0000;
			send_sample(s);
		end
	endtask

	task automatic random_phase(input int items);
		int left_items, len, base, spread;
		logic [11:0] px, py;
		left_items = items;
		while (left_items > 0) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: set_config(16'd1, 16'($urandom_range(0, 3)), 16'($urandom));
					1: set_config(16'($urandom_range(2, 40)), 16'($urandom_range(0, 8)), 16'hFFFF);
					2: set_config(16'($urandom_range(2, 40)), 16'($urandom_range(1, 12)), 16'd0);
					default: set_config(16'($urandom_range(0, 32)), 16'($urandom_range(0, 10)),
						16'($urandom));
				endcase
			end
			px = 12'($urandom);
			py = 12'($urandom);
			len = $urandom_range(1, 24);
			if ($urandom_range(0, 4) == 0) begin
				base = 0; spread = 65535;
			end else begin
				base = $urandom_range(0, 60000); spread = $urandom_range(0, 400);
			end
			for (int i = 0; i < len && left_items > 0; i++) begin
				// occasional stray coordinate inside a pixel run
				send_sample(make_sample(base, spread, ($urandom_range(0, 9) == 0) ? 12'($urandom) : px,
					py));
				left_items--;
			end
		end
	endtask

	task automatic test_random();
		snd_idle = 26; rcv_idle = 54;
		random_phase(100);
		snd_idle = 54; rcv_idle = 26;
		random_phase(100);
		snd_idle = 0; rcv_idle = 0;
		random_phase(100);
	endtask

	task automatic test_backpressure();
		set_config(16'd2, 16'd1, 16'd0);
		fork
			begin
				rcv_hold <= 1'b1;
				repeat (3000) @(posedge clk);
				rcv_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 40; i++) send_sample(make_sample(0, 65535, 12'($urandom), 12'($urandom)));
	endtask

	always @(posedge clk)
		m_tready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle);

	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[58:48], m_tuser,
				m_tdata[70:59], m_tdata[82:71]};
			pixels_seen++;
			if (m_tuser) converged_seen++;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected pixel beat: %h", got);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: exp r%h g%h b%h n%0d c%0d x%0d y%0d / got r%h g%h b%h n%0d c%0d x%0d y%0d",
							want.mean_red, want.mean_green, want.mean_blue, want.used, want.conv,
							want.x, want.y, got.mean_red, got.mean_green, got.mean_blue,
							got.used, got.conv, got.x, got.y);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			wd_count <= 0;
		else
			wd_count <= wd_count + 1;
		if (wd_count >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		acc_red = '0; acc_green = '0; acc_blue = '0;
		acc_illum = '0; acc_sq = '0; acc_cnt = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_pixel();
		test_random();
		test_backpressure();
		drain();
		if (pending_pixels.size() != 0) mismatches++;
		$display("covered %0d samples, %0d pixels (%0d converged), directed cases and stall",
			samples_sent, pixels_seen, converged_seen);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
